FILE: sv/integer_to_ascii_formatter_core_defines.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core defines
// assertion macros shared by the formatter rtl
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

// condition must hold at every edge out of reset
`define ITOA_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ITOA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// widths, conversion kinds and character table of the integer formatter
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;
  localparam int DIG_W   = 4;

  // decimal needs ten digit slots, hex eight
  localparam int BUF_DEPTH = 10;
  localparam int PTR_W     = $clog2(BUF_DEPTH);

  // quotient of a divide by ten: (x * RECIP10) >> QUO_SHIFT
  localparam logic [VALUE_W-1:0] RECIP10   = 32'hCCCC_CCCD;
  localparam int                 QUO_SHIFT = 35;
  localparam int                 QUO_W     = 2 * VALUE_W - QUO_SHIFT;

  localparam logic [KIND_W-1:0] KIND_SDEC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UDEC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEX  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [CHAR_W-1:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

endpackage

FILE: sv/itoa_if.sv
// ----------------------------------------------------------------------------
// itoa channel interfaces
// request channel (kind and value) and character channel
// ----------------------------------------------------------------------------
interface itoa_in_if
  import itoa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  req_type;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface itoa_out_if
  import itoa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

FILE: sv/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// formats one 32-bit value as signed decimal, unsigned decimal or hex ascii
// ----------------------------------------------------------------------------
// Each request carries a value and a conversion kind and produces its ascii
// characters most significant first, no leading zeros, with last set on the
// final one; a negative signed value gets a leading '-', kind 3 produces
// nothing. Digits are found least significant first into a small digit
// buffer: a reciprocal multiply for divide by ten gives each decimal digit
// (multiply, then quotient and remainder), a nibble shift gives each hex
// digit. The buffer is then read out one character per cycle while
// out_chan.ready is high. in_ready is held low from accept until the last
// character of the request is taken.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_core_defines.svh"

module integer_to_ascii_formatter_core
  import itoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  itoa_in_if.sink    in_chan,
  itoa_out_if.source out_chan
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_HEX  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [PTR_W-1:0] CNT_LIMIT = PTR_W'(BUF_DEPTH);

  logic [2:0]          state_r, state_nxt;
  logic [VALUE_W-1:0]  mag_r, mag_nxt;
  logic [QUO_W-1:0]    prod_r, prod_nxt;
  logic [PTR_W-1:0]    cnt_r, cnt_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic                sign_r, sign_nxt;

  logic [DIG_W-1:0]    buf_r [BUF_DEPTH];
  logic                buf_we;
  logic [DIG_W-1:0]    buf_wdata;

  logic [2*VALUE_W-1:0] mul_full;
  logic [DIG_W-1:0]     q10_lo;
  logic [DIG_W-1:0]     rem;
  logic                 in_fire;
  logic                 out_fire;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = out_chan.valid && out_chan.ready;

  assign out_chan.valid     = (state_r == S_EMIT);
  assign out_chan.char_code = sign_r ? CHAR_MINUS : HEX_CHARS[buf_r[ptr_r]];
  assign out_chan.last      = !sign_r && (ptr_r == '0);

  // shared divide-by-ten unit
  assign mul_full = {32'd0, mag_r} * {32'd0, RECIP10};
  // remainder only needs the low nibble: mag - 10*q is below ten
  assign q10_lo   = {prod_r[0], 3'b000} + {prod_r[2:0], 1'b0};
  assign rem      = mag_r[DIG_W-1:0] - q10_lo;

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    sign_nxt  = sign_r;
    buf_we    = 1'b0;
    buf_wdata = mag_r[DIG_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_chan.req_type != KIND_NONE) begin
          cnt_nxt  = '0;
          sign_nxt = (in_chan.req_type == KIND_SDEC) && in_chan.value[VALUE_W-1];
          mag_nxt  = sign_nxt ? (~in_chan.value + 32'd1) : in_chan.value;
          state_nxt = (in_chan.req_type == KIND_HEX) ? S_HEX : S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = mul_full[2*VALUE_W-1:QUO_SHIFT];
        state_nxt = S_SUB;
      end
      S_SUB: begin
        buf_we    = 1'b1;
        buf_wdata = rem;
        mag_nxt   = {{(VALUE_W-QUO_W){1'b0}}, prod_r};
        cnt_nxt   = cnt_r + PTR_W'(1);
        if (prod_r == '0) begin
          ptr_nxt   = cnt_r;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_HEX: begin
        buf_we    = 1'b1;
        buf_wdata = mag_r[DIG_W-1:0];
        mag_nxt   = mag_r >> DIG_W;
        cnt_nxt   = cnt_r + PTR_W'(1);
        if (mag_r[VALUE_W-1:DIG_W] == '0) begin
          ptr_nxt   = cnt_r;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_fire) begin
          if (sign_r) begin
            sign_nxt = 1'b0;
          end else if (ptr_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt = ptr_r - PTR_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    prod_r <= prod_nxt;
    cnt_r  <= cnt_nxt;
    ptr_r  <= ptr_nxt;
    sign_r <= sign_nxt;
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[cnt_r] <= buf_wdata;
    end
  end

  `ITOA_ASSERT_ALWAYS(a_no_overlap, !(in_chan.ready && out_chan.valid), "ready while sending")
  `ITOA_ASSERT_NEXT(a_last_idle, out_fire && out_chan.last, in_chan.ready, "no idle after last")
  `ITOA_ASSERT_NEXT(a_busy, in_fire && in_chan.req_type != KIND_NONE, !in_chan.ready, "not busy")
  `ITOA_ASSERT_ALWAYS(a_cnt_range, state_r == S_IDLE || cnt_r <= CNT_LIMIT, "digit overflow")

endmodule
